// File: hdl/cn0_spread_moving_average_alarm_defines.svh
// Assertion macros shared by the checker of the spread alarm block.
`ifndef CN0_SPREAD_MOVING_AVERAGE_ALARM_DEFINES_SVH
`define CN0_SPREAD_MOVING_AVERAGE_ALARM_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CN0SMA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CN0SMA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/cn0sma_pkg.sv
// Types, constants and codes of the carrier-to-noise spread alarm block.
`default_nettype none

package cn0sma_pkg;

    localparam int MAX_CHANNELS_DEF = 16;
    localparam int WINDOW_DEF       = 1000;

    localparam int READING_W  = 14;
    localparam int SPREAD_W   = 14;
    localparam int STATUS_W   = 2;
    localparam int MIN_CH_W   = 5;
    localparam int CFG_DATA_W = 14;
    localparam int CFG_IDX_W  = 1;

    localparam logic [MIN_CH_W-1:0] MIN_CHANNELS_RST = MIN_CH_W'(4);
    localparam logic [SPREAD_W-1:0] MIN_STDEV_RST    = SPREAD_W'(256);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_CHANNELS,
        CFG_MIN_STDEV
    } t_cfg_idx;

    typedef enum logic [STATUS_W-1:0] {
        STAT_SKIPPED,
        STAT_FILLING,
        STAT_NORMAL,
        STAT_ALARM
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_ROOT,
        ST_ROOT_WAIT,
        ST_DEV_WAIT,
        ST_MEAN,
        ST_MEAN_WAIT
    } t_state;

    typedef struct packed {
        logic [READING_W-1:0] cn0_reading;
        logic                 last_in_epoch;
    } t_in_item;

    typedef struct packed {
        t_status              status;
        logic [SPREAD_W-1:0]  window_mean_spread;
        logic [SPREAD_W-1:0]  epoch_spread;
    } t_out_item;

endpackage

`default_nettype wire

// File: hdl/cn0_spread_moving_average_alarm.sv
// Top level of the carrier-to-noise spread alarm with a moving-average window.
//
//  Channel   Ports                              Handshake
//  --------  ---------------------------------  ------------------------------
//  item in   i_item (reading, last flag)        taken when start && !busy
//  config    i_cfg_we, i_cfg_idx, i_cfg_data    written when i_cfg_we is high
//  result    o_result (status, mean, spread)    shown for one cycle on o_done
//
// An item without the last flag is taken and busy stays low.
// The last item of an epoch holds busy through ST_EVAL, ST_ROOT, ST_ROOT_WAIT,
// ST_DEV_WAIT, ST_MEAN and, once the ring is full, ST_MEAN_WAIT; it waits on
// the bit-serial square root and the bit-serial divide by the channel count.
// An epoch with too few channels holds busy only in ST_EVAL. The result appears
// in the cycle busy falls. The ring memory needs no clearing pass after reset;
// its fill count guards reads. The receiver cannot stall.
`default_nettype none

module cn0_spread_moving_average_alarm #(
    parameter int MAX_CHANNELS = cn0sma_pkg::MAX_CHANNELS_DEF,
    parameter int WINDOW       = cn0sma_pkg::WINDOW_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  start,
    output logic                                       busy,
    input  wire cn0sma_pkg::t_in_item                  i_item,
    input  wire logic                                  i_cfg_we,
    input  wire logic [cn0sma_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [cn0sma_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output logic                                       o_done,
    output cn0sma_pkg::t_out_item                      o_result
);

    import cn0sma_pkg::*;

    localparam int CNT_W    = $clog2(MAX_CHANNELS + 1);
    localparam int SUM_W    = READING_W + CNT_W;
    localparam int SQS_W    = 2 * READING_W + CNT_W;
    localparam int PROD_W   = 2 * SUM_W;
    localparam int ROOT_W   = PROD_W / 2;
    localparam int WIN_W    = $clog2(WINDOW + 1);
    localparam int AW       = $clog2(WINDOW);
    localparam int WS_W     = SPREAD_W + WIN_W;
    localparam int DIV_N_W  = ROOT_W;
    localparam int DIV_D_W  = CNT_W;
    localparam int CMP_W    = (CNT_W > MIN_CH_W) ? CNT_W : MIN_CH_W;
    localparam int MEAN_SH  = WS_W + $clog2(WINDOW);
    localparam int MEAN_M_W = WS_W + 1;
    localparam int MEAN_P_W = WS_W + MEAN_M_W;
    // Rounded-up reciprocal of WINDOW; exact truncated quotient for every window sum.
    localparam longint unsigned MEAN_M =
        ((64'd1 << MEAN_SH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);

    // Configuration registers.
    logic [MIN_CH_W-1:0]  r_min_ch;
    logic [SPREAD_W-1:0]  r_min_stdev;

    // Epoch accumulators.
    logic [SUM_W-1:0]     r_sum,   n_sum;
    logic [SQS_W-1:0]     r_sqs,   n_sqs;
    logic [CNT_W-1:0]     r_cnt,   n_cnt;

    // Ring bookkeeping.
    logic [AW-1:0]        r_wptr,  n_wptr;
    logic [WIN_W-1:0]     r_fill,  n_fill;
    logic [WS_W-1:0]      r_wsum,  n_wsum;

    // Epoch evaluation.
    t_state               r_state, n_state;
    logic [PROD_W-1:0]    r_a,     n_a;
    logic [PROD_W-1:0]    r_b,     n_b;
    logic [SPREAD_W-1:0]  r_spread, n_spread;
    t_out_item            r_out,   n_out;
    logic                 r_done,  n_done;

    logic                 accept;
    logic                 room;
    logic [2*READING_W-1:0] sq;
    logic                 ring_full;
    logic [WS_W:0]        wsum_upd;
    logic [MEAN_P_W-1:0]  mean_prod;
    logic [SPREAD_W-1:0]  mean;

    logic                 sqrt_start;
    logic [PROD_W-1:0]    sqrt_rad;
    logic                 sqrt_done;
    logic [ROOT_W-1:0]    sqrt_root;

    logic                 div_start;
    logic [DIV_N_W-1:0]   div_num;
    logic [DIV_D_W-1:0]   div_den;
    logic                 div_done;
    logic [DIV_N_W-1:0]   div_quot;

    logic                 ram_we;
    logic                 ram_re;
    logic [SPREAD_W-1:0]  ram_rdata;

    assign accept    = start && !busy;
    assign room      = (r_cnt < CNT_W'(MAX_CHANNELS));
    assign sq        = (2*READING_W)'(i_item.cn0_reading) * (2*READING_W)'(i_item.cn0_reading);
    assign ring_full = (r_fill == WIN_W'(WINDOW));
    assign mean_prod = MEAN_P_W'(r_wsum) * MEAN_P_W'(MEAN_M);
    assign mean      = mean_prod[MEAN_SH +: SPREAD_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_ch    <= MIN_CHANNELS_RST;
            r_min_stdev <= MIN_STDEV_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_MIN_CHANNELS: r_min_ch    <= MIN_CH_W'(i_cfg_data);
                CFG_MIN_STDEV:    r_min_stdev <= i_cfg_data;
            endcase
        end
    end

    always_comb begin
        n_state    = r_state;
        n_sum      = r_sum;
        n_sqs      = r_sqs;
        n_cnt      = r_cnt;
        n_wptr     = r_wptr;
        n_fill     = r_fill;
        n_wsum     = r_wsum;
        n_a        = r_a;
        n_b        = r_b;
        n_spread   = r_spread;
        n_out      = r_out;
        n_done     = 1'b0;
        sqrt_start = 1'b0;
        div_start  = 1'b0;
        div_num    = DIV_N_W'(sqrt_root);
        div_den    = DIV_D_W'(r_cnt);
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        sqrt_rad   = (r_a > r_b) ? (r_a - r_b) : '0;
        // The oldest spread leaves the window sum only once the ring is full.
        wsum_upd   = (WS_W+1)'(r_wsum) - (ring_full ? (WS_W+1)'(ram_rdata) : '0)
                     + (WS_W+1)'(r_spread);

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (room) begin
                        n_sum = r_sum + SUM_W'(i_item.cn0_reading);
                        n_sqs = r_sqs + SQS_W'(sq);
                        n_cnt = r_cnt + CNT_W'(1);
                    end
                    if (i_item.last_in_epoch) begin
                        n_state = ST_EVAL;
                    end
                end
            end
            ST_EVAL: begin
                if (CMP_W'(r_cnt) < CMP_W'(r_min_ch)) begin
                    n_out   = '{status: STAT_SKIPPED, window_mean_spread: '0,
                                epoch_spread: '0};
                    n_done  = 1'b1;
                    n_sum   = '0;
                    n_sqs   = '0;
                    n_cnt   = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_a     = PROD_W'(r_cnt) * PROD_W'(r_sqs);
                    n_b     = PROD_W'(r_sum) * PROD_W'(r_sum);
                    ram_re  = 1'b1;
                    n_state = ST_ROOT;
                end
            end
            ST_ROOT: begin
                sqrt_start = 1'b1;
                n_state    = ST_ROOT_WAIT;
            end
            ST_ROOT_WAIT: begin
                if (sqrt_done) begin
                    div_start = 1'b1;
                    n_state   = ST_DEV_WAIT;
                end
            end
            ST_DEV_WAIT: begin
                if (div_done) begin
                    // An empty epoch has no divisor; its spread is zero.
                    n_spread = (r_cnt == '0) ? '0 : SPREAD_W'(div_quot);
                    n_state  = ST_MEAN;
                end
            end
            ST_MEAN: begin
                ram_we = 1'b1;
                n_wsum = WS_W'(wsum_upd);
                n_fill = ring_full ? r_fill : r_fill + WIN_W'(1);
                n_wptr = (r_wptr == AW'(WINDOW - 1)) ? '0 : r_wptr + AW'(1);
                if (ring_full || (r_fill == WIN_W'(WINDOW - 1))) begin
                    n_state = ST_MEAN_WAIT;
                end else begin
                    n_out   = '{status: STAT_FILLING, window_mean_spread: '0,
                                epoch_spread: r_spread};
                    n_done  = 1'b1;
                    n_sum   = '0;
                    n_sqs   = '0;
                    n_cnt   = '0;
                    n_state = ST_IDLE;
                end
            end
            ST_MEAN_WAIT: begin
                // The window sum already holds the newest spread here.
                n_out.status = (mean < r_min_stdev) ? STAT_ALARM : STAT_NORMAL;
                n_out.window_mean_spread = mean;
                n_out.epoch_spread       = r_spread;
                n_done  = 1'b1;
                n_sum   = '0;
                n_sqs   = '0;
                n_cnt   = '0;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_sum   <= '0;
            r_sqs   <= '0;
            r_cnt   <= '0;
            r_wptr  <= '0;
            r_fill  <= '0;
            r_wsum  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sum   <= n_sum;
            r_sqs   <= n_sqs;
            r_cnt   <= n_cnt;
            r_wptr  <= n_wptr;
            r_fill  <= n_fill;
            r_wsum  <= n_wsum;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a      <= n_a;
        r_b      <= n_b;
        r_spread <= n_spread;
        r_out    <= n_out;
    end

    cn0sma_isqrt #(
        .RAD_W (PROD_W)
    ) u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sqrt_start),
        .i_radicand (sqrt_rad),
        .o_done     (sqrt_done),
        .o_root     (sqrt_root)
    );

    cn0sma_div #(
        .NUM_W (DIV_N_W),
        .DEN_W (DIV_D_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    cn0sma_ram #(
        .WIDTH (SPREAD_W),
        .DEPTH (WINDOW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wptr),
        .i_wdata (r_spread),
        .i_re    (ram_re),
        .i_raddr (r_wptr),
        .o_rdata (ram_rdata)
    );

    assign busy     = (r_state != ST_IDLE);
    assign o_done   = r_done;
    assign o_result = r_out;

endmodule

`default_nettype wire

// File: hdl/cn0sma_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module cn0sma_ram #(
    parameter int WIDTH = 14,
    parameter int DEPTH = 1000
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: hdl/cn0sma_isqrt.sv
// Iterative integer square root, one result bit per cycle.
`default_nettype none

module cn0sma_isqrt #(
    parameter int RAD_W = 38
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [RAD_W-1:0]     i_radicand,
    output logic                      o_done,
    output logic      [RAD_W/2-1:0]   o_root
);

    localparam int ROOT_W = RAD_W / 2;
    localparam int STEP_W = (ROOT_W > 1) ? $clog2(ROOT_W) : 1;

    logic [RAD_W-1:0]  r_rad;
    logic [ROOT_W+1:0] r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [STEP_W-1:0] r_step;
    logic              r_run;
    logic              r_done;

    logic [ROOT_W+1:0] rem_sh;
    logic [ROOT_W+1:0] trial;
    logic              fits;

    always_comb begin
        rem_sh = {r_rem[ROOT_W-1:0], r_rad[RAD_W-1 -: 2]};
        trial  = {r_root, 2'b01};
        fits   = (rem_sh >= trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
            end else if (r_run && (r_step == STEP_W'(ROOT_W - 1))) begin
                r_run  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
            r_step <= '0;
        end else if (r_run) begin
            r_rad  <= {r_rad[RAD_W-3:0], 2'b00};
            r_step <= r_step + STEP_W'(1);
            if (fits) begin
                r_rem  <= rem_sh - trial;
                r_root <= {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= rem_sh;
                r_root <= {r_root[ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

`default_nettype wire

// File: hdl/cn0sma_div.sv
// Iterative restoring divider, one quotient bit per cycle.
`default_nettype none

module cn0sma_div #(
    parameter int NUM_W = 24,
    parameter int DEN_W = 10
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [NUM_W-1:0]  i_num,
    input  wire logic [DEN_W-1:0]  i_den,
    output logic                   o_done,
    output logic      [NUM_W-1:0]  o_quot
);

    localparam int STEP_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

    logic [NUM_W-1:0]  r_quo;
    logic [DEN_W-1:0]  r_rem;
    logic [DEN_W-1:0]  r_den;
    logic [STEP_W-1:0] r_step;
    logic              r_run;
    logic              r_done;

    logic [DEN_W:0]    rem_sh;
    logic              fits;

    always_comb begin
        rem_sh = {r_rem, r_quo[NUM_W-1]};
        fits   = (rem_sh >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
            end else if (r_run && (r_step == STEP_W'(NUM_W - 1))) begin
                r_run  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo  <= i_num;
            r_rem  <= '0;
            r_den  <= i_den;
            r_step <= '0;
        end else if (r_run) begin
            r_step <= r_step + STEP_W'(1);
            if (fits) begin
                r_rem <= DEN_W'(rem_sh - {1'b0, r_den});
                r_quo <= {r_quo[NUM_W-2:0], 1'b1};
            end else begin
                r_rem <= DEN_W'(rem_sh);
                r_quo <= {r_quo[NUM_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

`default_nettype wire

// File: hdl/cn0sma_checker.sv
// Port-level checker of the spread alarm block and its bind to the top level.
`default_nettype none
`include "cn0_spread_moving_average_alarm_defines.svh"

module cn0sma_checker (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  start,
    input  wire logic                                  busy,
    input  wire cn0sma_pkg::t_in_item                  i_item,
    input  wire logic                                  o_done,
    input  wire cn0sma_pkg::t_out_item                 o_result
);

    import cn0sma_pkg::*;

    // A result is only shown once the epoch work is over.
    `CN0SMA_ASSERT_NOW(a_done_not_busy, i_clk, i_rst_n, o_done, !busy, "result while busy")

    // An item that does not end its epoch gives no result and no wait.
    `CN0SMA_ASSERT_NEXT(a_mid_epoch_quiet, i_clk, i_rst_n, start && !busy && !i_item.last_in_epoch, !o_done && !busy, "mid-epoch item produced result or stall")

    // The last item of an epoch always starts an evaluation.
    `CN0SMA_ASSERT_NEXT(a_last_busy, i_clk, i_rst_n, start && !busy && i_item.last_in_epoch, busy, "epoch end did not start evaluation")

    // Without a full window the mean reads zero, and a skipped epoch has no spread.
    `CN0SMA_ASSERT_NOW(a_mean_zero, i_clk, i_rst_n, o_done && (o_result.status == STAT_SKIPPED || o_result.status == STAT_FILLING), o_result.window_mean_spread == '0 && (o_result.status != STAT_SKIPPED || o_result.epoch_spread == '0), "nonzero field on skipped or filling result")

    // One epoch end gives exactly one result cycle.
    `CN0SMA_ASSERT_NEXT(a_single_done, i_clk, i_rst_n, o_done, !o_done, "result strobe held longer than one cycle")

endmodule

bind cn0_spread_moving_average_alarm cn0sma_checker u_cn0sma_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_item   (i_item),
    .o_done   (o_done),
    .o_result (o_result)
);

`default_nettype wire

// File: bench/testbench.sv
// Self-checking testbench for the carrier-to-noise spread alarm block.
`timescale 1ns / 100ps

module testbench;
    import cn0sma_pkg::*;

    localparam int MAX_CH         = MAX_CHANNELS_DEF;
    localparam int WIN            = WINDOW_DEF;
    localparam int READING_MAX    = (1 << READING_W) - 1;
    localparam int LATENCY_CYCLES = 100;
    localparam int DRAIN_LIMIT    = 2000;

    // Predicts the report of each epoch and keeps the reports still owed by the block.
    class spread_alarm_model;
        logic [MIN_CH_W-1:0] min_channels;
        logic [SPREAD_W-1:0] min_stdev;
        longint unsigned     reading_sum;
        longint unsigned     square_sum;
        int unsigned         reading_count;
        logic [SPREAD_W-1:0] spread_ring [WIN];
        int unsigned         write_ptr;
        int unsigned         fill_count;
        longint unsigned     window_sum;
        t_out_item           expected_reports [$];
        int unsigned         mismatch_count;

        function new();
            min_channels   = MIN_CHANNELS_RST;
            min_stdev      = MIN_STDEV_RST;
            reading_sum    = 0;
            square_sum     = 0;
            reading_count  = 0;
            write_ptr      = 0;
            fill_count     = 0;
            window_sum     = 0;
            mismatch_count = 0;
        endfunction

        function void set_register(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_MIN_CHANNELS: min_channels = data[MIN_CH_W-1:0];
                CFG_MIN_STDEV:    min_stdev = data[SPREAD_W-1:0];
                default:          ;
            endcase
        endfunction

        function void take_reading(t_in_item item);
            longint unsigned     reading;
            longint unsigned     scaled_squares;
            longint unsigned     squared_sum;
            longint unsigned     diff;
            longint unsigned     root;
            longint unsigned     trial;
            longint unsigned     mean;
            logic [SPREAD_W-1:0] spread;
            t_out_item           report;
            int                  b;

            reading = longint'(item.cn0_reading);
            if (reading_count < MAX_CH) begin
                reading_sum += reading;
                square_sum += reading * reading;
                reading_count++;
            end
            if (!item.last_in_epoch) begin
                return;
            end

            mean = 0;
            spread = '0;
            if (reading_count < min_channels) begin
                report.status = STAT_SKIPPED;
            end else begin
                scaled_squares = reading_count * square_sum;
                squared_sum = reading_sum * reading_sum;
                if (scaled_squares > squared_sum) begin
                    diff = scaled_squares - squared_sum;
                    root = 0;
                    for (b = 19; b >= 0; b--) begin
                        trial = root | (64'd1 << b);
                        if (trial * trial <= diff) begin
                            root = trial;
                        end
                    end
                    spread = SPREAD_W'(root / reading_count);
                end
                // Once the ring is full the oldest spread drops out of the sum.
                if (fill_count >= WIN) begin
                    window_sum -= spread_ring[write_ptr];
                end else begin
                    fill_count++;
                end
                spread_ring[write_ptr] = spread;
                window_sum += spread;
                write_ptr = (write_ptr + 1 >= WIN) ? 0 : write_ptr + 1;
                if (fill_count >= WIN) begin
                    mean = window_sum / WIN;
                    report.status = (mean < min_stdev) ? STAT_ALARM : STAT_NORMAL;
                end else begin
                    report.status = STAT_FILLING;
                end
            end
            report.window_mean_spread = SPREAD_W'(mean);
            report.epoch_spread = spread;
            reading_sum = 0;
            square_sum = 0;
            reading_count = 0;
            expected_reports = {expected_reports, report};
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;

            if (expected_reports.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("unexpected report: status %0d mean %0d spread %0d",
                             got.status, got.window_mean_spread, got.epoch_spread);
                end
                return;
            end
            want = expected_reports.pop_front();
            if (got.status !== want.status || got.window_mean_spread !== want.window_mean_spread
                    || got.epoch_spread !== want.epoch_spread) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("report mismatch at %0t: status %0d/%0d mean %0d/%0d spread %0d/%0d",
                             $realtime, want.status, got.status, want.window_mean_spread,
                             got.window_mean_spread, want.epoch_spread, got.epoch_spread);
                    $display("    (expected/actual)");
                end
            end
        endfunction

        function int unsigned pending();
            return expected_reports.size();
        endfunction

        // Average of the spreads now held in the window, used to place the alarm threshold.
        function int unsigned running_average();
            return (fill_count == 0) ? 0 : int'(window_sum / fill_count);
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    t_in_item              feed_item = '0;
    logic                  cfg_we = 1'b0;
    t_cfg_idx              cfg_idx = CFG_MIN_CHANNELS;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  done;
    t_out_item             result;

    spread_alarm_model alarm_model;

    cn0_spread_moving_average_alarm #(
        .MAX_CHANNELS(MAX_CH),
        .WINDOW      (WIN)
    ) uut (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .start     (start),
        .busy      (busy),
        .i_item    (feed_item),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data),
        .o_done    (done),
        .o_result  (result)
    );

    always #10 clk = ~clk;

    always @(posedge clk) begin
        if (rst_n) begin
            if (done) begin
                alarm_model.check_result(result);
            end
            if (start && !busy) begin
                alarm_model.take_reading(feed_item);
            end
        end
    end

    // Offers one reading after a random gap and returns once it is taken and busy is low.
    task automatic send_reading(input int unsigned reading, input logic last,
                                input int unsigned idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start <= 1'b1;
        feed_item.cn0_reading <= READING_W'(reading);
        feed_item.last_in_epoch <= last;
        @(posedge clk);
        while (busy) begin
            @(posedge clk);
        end
    endtask

    // Stops feeding, waits until every owed report is in or the drain limit runs out, then lets the block go quiet.
    task automatic settle();
        int unsigned waited;

        waited = 0;
        @(negedge clk);
        start <= 1'b0;
        while (alarm_model.pending() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge clk);
            waited++;
        end
        repeat (LATENCY_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input t_cfg_idx idx, input int unsigned value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= CFG_DATA_W'(value);
        @(negedge clk);
        cfg_we <= 1'b0;
        alarm_model.set_register(idx, CFG_DATA_W'(value));
    endtask

    initial begin : stimulus
        int unsigned phase;
        int unsigned epochs;
        int unsigned ep;
        int unsigned i;
        int unsigned len;
        int unsigned pick;
        int unsigned scale_bits;
        int unsigned base;
        int unsigned reading;
        int unsigned idle_pct;
        int unsigned channels_setting;
        int unsigned stdev_setting;

        alarm_model = new();
        scale_bits = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Too few channels under the reset setting, so the epoch is skipped.
        send_reading(0, 1'b0, 0);
        send_reading(READING_MAX, 1'b0, 0);
        send_reading(1, 1'b1, 0);
        // Extreme readings alternating give the largest spread.
        for (i = 0; i < 4; i++) begin
            send_reading((i % 2) ? READING_MAX : 0, i == 3, 0);
        end
        settle();
        write_register(CFG_MIN_CHANNELS, 0);
        send_reading(12345, 1'b1, 0);
        settle();
        write_register(CFG_MIN_CHANNELS, MAX_CH);
        write_register(CFG_MIN_STDEV, READING_MAX);
        // One reading past the channel limit, which must be ignored.
        for (i = 0; i <= MAX_CH; i++) begin
            send_reading((i % 2) ? 0 : READING_MAX, i == MAX_CH, 0);
        end

        for (phase = 0; phase < 6; phase++) begin
            settle();
            idle_pct = (phase < 2) ? 10 : (phase < 4) ? 81 : 0;
            case (phase)
                0: begin
                    channels_setting = 1;
                    stdev_setting = 0;
                    epochs = 45;
                end
                1: begin
                    channels_setting = MAX_CH;
                    stdev_setting = READING_MAX;
                    epochs = 40;
                end
                2: begin
                    channels_setting = 0;
                    stdev_setting = 0;
                    epochs = 45;
                end
                3: begin
                    channels_setting = $urandom_range(3, 1);
                    stdev_setting = alarm_model.running_average();
                    epochs = 40;
                end
                4: begin
                    channels_setting = 2;
                    stdev_setting = READING_MAX;
                    epochs = 40;
                end
                default: begin
                    channels_setting = $urandom_range(4, 1);
                    stdev_setting = alarm_model.running_average();
                    epochs = 45;
                end
            endcase
            write_register(CFG_MIN_CHANNELS, channels_setting);
            write_register(CFG_MIN_STDEV, stdev_setting);

            for (ep = 0; ep < epochs; ep++) begin
                // The spread scale drifts in chunks so the window mean wanders.
                if (ep % 50 == 0) begin
                    scale_bits = $urandom_range(READING_W);
                end
                pick = $urandom_range(99);
                if (pick < 70) begin
                    len = $urandom_range(2, 1);
                end else if (pick < 90) begin
                    len = $urandom_range(8, 3);
                end else begin
                    len = $urandom_range(MAX_CH + 4, 9);
                end
                base = $urandom_range(READING_MAX);
                for (i = 0; i < len; i++) begin
                    case ($urandom_range(15))
                        0: reading = 0;
                        1: reading = READING_MAX;
                        default: begin
                            reading = base + $urandom_range((1 << scale_bits) - 1);
                            if (reading > READING_MAX) begin
                                reading = READING_MAX;
                            end
                        end
                    endcase
                    send_reading(reading, i == len - 1, idle_pct);
                end
            end
        end

        settle();
        if (alarm_model.mismatch_count == 0 && alarm_model.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin : watchdog
        #50_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
